@@ hw/rtl/slad_pkg.sv @@
// ----------------------------------------------------------------------------
// slad_pkg - shared types and constants for the store/load alias detector
// Field masks for the two recognized load/store encodings, key layout and
// table sizing.
// ----------------------------------------------------------------------------
package slad_pkg;

    localparam int STORE_SLOTS = 32;
    localparam int SLOT_IDX_W  = (STORE_SLOTS > 1) ? $clog2(STORE_SLOTS) : 1;
    localparam int SLOT_CNT_W  = $clog2(STORE_SLOTS + 1);

    localparam int WORD_W = 32;
    localparam int KEY_W  = 20;

    localparam logic [WORD_W-1:0] IMM12_MASK  = 32'h3B00_0000;
    localparam logic [WORD_W-1:0] IMM12_MATCH = 32'h3900_0000;
    localparam logic [WORD_W-1:0] IMM9_MASK   = 32'h3B20_0C00;
    localparam logic [WORD_W-1:0] IMM9_MATCH  = 32'h3800_0000;

    localparam logic [1:0] OPC_STORE = 2'd0;

    // decoded instruction word
    typedef struct packed {
        logic             hit;      // recognized load/store form
        logic             is_store;
        logic [KEY_W-1:0] key;
    } t_dec;

endpackage

@@ hw/rtl/slad_decode.sv @@
// ----------------------------------------------------------------------------
// slad_decode - load/store form decoder
// Recognizes the unsigned imm12 and unscaled imm9 forms and packs the
// format/size/base/offset key.
// ----------------------------------------------------------------------------
module slad_decode (
    input  logic [slad_pkg::WORD_W-1:0] i_word,
    output slad_pkg::t_dec              o_dec
);
    import slad_pkg::*;

    logic is_imm12;
    logic is_imm9;

    assign is_imm12 = ((i_word & IMM12_MASK) == IMM12_MATCH);
    assign is_imm9  = ((i_word & IMM9_MASK) == IMM9_MATCH);

    always_comb begin
        o_dec.hit      = is_imm12 | is_imm9;
        o_dec.is_store = (i_word[23:22] == OPC_STORE);
        // imm12 takes priority over imm9 when both patterns match
        if (is_imm12) begin
            o_dec.key = {1'b0, i_word[31:30], i_word[9:5], i_word[21:10]};
        end else begin
            o_dec.key = {1'b1, i_word[31:30], i_word[9:5], 3'b000, i_word[20:12]};
        end
    end

endmodule

@@ hw/rtl/slad_table.sv @@
// ----------------------------------------------------------------------------
// slad_table - store key table and sticky hazard flag
// Appends store keys, compares load keys against every filled slot in
// parallel, and clears on the last word of a region.
// ----------------------------------------------------------------------------
module slad_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic           i_last,
    input  slad_pkg::t_dec i_dec,
    output logic           o_hazard
);
    import slad_pkg::*;

    logic [KEY_W-1:0]      r_keys [STORE_SLOTS];
    logic [SLOT_CNT_W-1:0] r_count;
    logic [SLOT_CNT_W-1:0] n_count;
    logic                  r_hazard;
    logic                  n_hazard;
    logic [STORE_SLOTS-1:0] slot_match;
    logic                  load_hit;
    logic                  do_store;

    always_comb begin
        for (int i = 0; i < STORE_SLOTS; i++) begin
            slot_match[i] = (SLOT_CNT_W'(i) < r_count) && (r_keys[i] == i_dec.key);
        end
    end

    assign load_hit = i_dec.hit && !i_dec.is_store && (|slot_match);
    assign do_store = i_fire && i_dec.hit && i_dec.is_store &&
                      (r_count < SLOT_CNT_W'(STORE_SLOTS));

    // flag as seen by the last word, including its own compare
    assign o_hazard = r_hazard | load_hit;

    always_comb begin
        n_count  = r_count;
        n_hazard = r_hazard;
        if (i_fire) begin
            if (i_last) begin
                n_count  = '0;
                n_hazard = 1'b0;
            end else begin
                n_hazard = r_hazard | load_hit;
                if (do_store) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_hazard <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_hazard <= n_hazard;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_store && !i_last) begin
            r_keys[r_count[SLOT_IDX_W-1:0]] <= i_dec.key;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOT_CNT_W'(STORE_SLOTS))
        else $error("store count past table size");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_last) |=> (r_count == '0 && !r_hazard))
        else $error("state not cleared after last word");

    a_store_appends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_store && !i_last) |=> (r_count == $past(r_count) + 1'b1))
        else $error("store did not advance count");

    a_hazard_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hazard && !(i_fire && i_last)) |=> r_hazard)
        else $error("hazard flag dropped inside a region");

endmodule

@@ hw/rtl/store_load_alias_detector_top.sv @@
// ----------------------------------------------------------------------------
// store_load_alias_detector_top - store/load alias detector
// Stream-in instruction words, stream-out one hazard word per region.
// ----------------------------------------------------------------------------
// One instruction word is taken every cycle unless the input stalls. While a
// word is in the input register it is decoded and its key is compared against
// all filled store slots at once; the table and the hazard flag update as it
// leaves that register. The word marked tlast produces one output word (bit 0 =
// hazard) via the output register after the input register, and clears the table.
// The input stalls only when a last word is in the input register while the
// previous result still waits in the output register. No clearing pass after reset.
// ----------------------------------------------------------------------------
module store_load_alias_detector_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [slad_pkg::WORD_W-1:0] s_axis_tdata,  // [31:0] instr_word
    input  logic                        s_axis_tlast,  // last
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata   // [0] hazard, [7:1] zero
);
    import slad_pkg::*;

    logic              r_in_valid;
    logic [WORD_W-1:0] r_in_word;
    logic              r_in_last;
    logic              r_out_valid;
    logic              r_out_hazard;
    logic              advance;
    logic              fire;
    logic              hazard;
    t_dec              dec;

    // a last word may move only if the output register has room
    assign advance = !(r_in_last && r_out_valid && !m_axis_tready);
    assign fire    = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_in_last  <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
            r_in_last  <= s_axis_tvalid && s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_word <= s_axis_tdata;
        end
    end

    slad_decode u_decode (
        .i_word (r_in_word),
        .o_dec  (dec)
    );

    slad_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_last   (r_in_last),
        .i_dec    (dec),
        .o_hazard (hazard)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_last) begin
            r_out_hazard <= hazard;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_hazard};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(fire && r_in_last))
        else $error("pending result overwritten");

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |=> r_out_valid)
        else $error("last word gave no result");

    a_nonlast_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_last) |-> s_axis_tready)
        else $error("input stalled on a non-last word");

endmodule

@@ bench/tb_store_load_alias_detector_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_store_load_alias_detector_top - stream bench for the alias detector
// Feeds regions of instruction words (directed corner regions, then random
// regions built from a small pool of base registers and offsets so loads
// often hit earlier stores) and checks each hazard word against an in-bench
// scan of the same words. Both sides idle at random; the receiver also holds
// off for long stretches to back the block up.
// ----------------------------------------------------------------------------
module tb_store_load_alias_detector_top;

    import slad_pkg::*;

    localparam logic [1:0] OPC_LOAD_U   = 2'd1;
    localparam logic [1:0] OPC_LOAD_S64 = 2'd2;
    localparam logic [1:0] OPC_LOAD_S32 = 2'd3;

    localparam int RANDOM_ITEMS = 700;
    localparam int LONG_HOLD    = 150;

    typedef struct packed {
        logic        fmt;   // 0 = imm12, 1 = unscaled imm9
        logic [1:0]  size;
        logic [4:0]  rn;
        logic [11:0] off;
    } t_mem_ref;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
        int                idle;    // idle cycles after this word
        bit                drain;   // hold here until all hazard words are back
    } t_scan_item;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata  = '0;   // [31:0] instr_word
    logic              s_axis_tlast  = 1'b0; // last
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;         // [0] hazard, [7:1] zero

    t_scan_item        pending_words[$];
    logic              expected_hazards[$];
    t_scan_item        next_word;

    logic [KEY_W-1:0]  store_key_tbl[STORE_SLOTS];
    int                store_key_cnt = 0;
    logic              alias_seen    = 1'b0;

    int                mismatch_count = 0;
    int                scanned_items  = 0;
    int                send_idle_left = 0;
    int                recv_hold_left = 0;
    int                hazards_seen   = 0;
    bit                quiet_gaps     = 1'b0;
    bit                mid_drained    = 1'b0;

    store_load_alias_detector_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // alias scan model
    // ------------------------------------------------------------------
    function automatic t_dec decode_word(input logic [WORD_W-1:0] w);
        t_dec d;
        d.hit      = 1'b1;
        d.is_store = (w[23:22] == OPC_STORE);
        d.key      = '0;
        if ((w & IMM12_MASK) == IMM12_MATCH) begin
            d.key = {1'b0, w[31:30], w[9:5], w[21:10]};
        end else if ((w & IMM9_MASK) == IMM9_MATCH) begin
            d.key = {1'b1, w[31:30], w[9:5], 3'b000, w[20:12]};
        end else begin
            d.hit = 1'b0;
        end
        return d;
    endfunction

    task automatic track_alias_word(input logic [WORD_W-1:0] w, input logic last);
        t_dec d;
        d = decode_word(w);
        if (d.hit) begin
            if (d.is_store) begin
                // table full: the store is dropped
                if (store_key_cnt < STORE_SLOTS) begin
                    store_key_tbl[store_key_cnt] = d.key;
                    store_key_cnt++;
                end
            end else begin
                for (int i = 0; i < store_key_cnt; i++) begin
                    if (store_key_tbl[i] == d.key) alias_seen = 1'b1;
                end
            end
        end
        if (last) begin
            expected_hazards.push_back(alias_seen);
            store_key_cnt = 0;
            alias_seen    = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    function automatic t_mem_ref mk_ref(input logic fmt, input logic [1:0] size,
                                        input logic [4:0] rn, input logic [11:0] off);
        t_mem_ref r;
        r.fmt  = fmt;
        r.size = size;
        r.rn   = rn;
        r.off  = fmt ? {3'b000, off[8:0]} : off;
        return r;
    endfunction

    function automatic t_mem_ref random_ref();
        logic        fmt;
        logic [4:0]  rn;
        logic [11:0] off;
        fmt = 1'($urandom_range(0, 1));
        rn  = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
        off = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 3)) : 12'($urandom());
        return mk_ref(fmt, 2'($urandom_range(0, 3)), rn, off);
    endfunction

    function automatic logic [WORD_W-1:0] encode_ref(input t_mem_ref r, input logic [1:0] opc);
        logic [4:0] rt;
        logic       vbit;
        rt   = 5'($urandom_range(0, 31));
        vbit = 1'($urandom_range(0, 1));
        if (!r.fmt) return {r.size, 3'b111, vbit, 2'b01, opc, r.off, r.rn, rt};
        return {r.size, 3'b111, vbit, 2'b00, opc, 1'b0, r.off[8:0], 2'b00, r.rn, rt};
    endfunction

    task automatic add_word(input logic [WORD_W-1:0] w, input logic last);
        t_scan_item it;
        it.word  = w;
        it.last  = last;
        it.idle  = quiet_gaps ? 0 : $urandom_range(0, 9);
        it.drain = 1'b0;
        pending_words.push_back(it);
        scanned_items++;
    endtask

    task automatic add_drain();
        t_scan_item it;
        it.word  = '0;
        it.last  = 1'b0;
        it.idle  = 0;
        it.drain = 1'b1;
        pending_words.push_back(it);
    endtask

    task automatic add_random_region();
        t_mem_ref          stores[$];
        t_mem_ref          r;
        logic [WORD_W-1:0] w;
        int                len;
        int                roll;
        int                store_pct;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            len       = $urandom_range(33, 45);   // overflow the key table
            store_pct = 80;
        end else if (roll < 15) begin
            len       = $urandom_range(11, 30);
            store_pct = 45;
        end else begin
            len       = $urandom_range(1, 10);
            store_pct = 40;
        end
        for (int n = 0; n < len; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                w = $urandom();
            end else if (roll < 12) begin
                // one decode bit off a valid form
                w = encode_ref(random_ref(), 2'($urandom_range(0, 3)));
                case ($urandom_range(0, 7))
                    0: w[29] = ~w[29];
                    1: w[28] = ~w[28];
                    2: w[27] = ~w[27];
                    3: w[25] = ~w[25];
                    4: w[24] = ~w[24];
                    5: w[21] = ~w[21];
                    6: w[11] = ~w[11];
                    default: w[10] = ~w[10];
                endcase
            end else if (roll < 12 + store_pct * 88 / 100) begin
                r = random_ref();
                stores.push_back(r);
                w = encode_ref(r, OPC_STORE);
            end else begin
                if (stores.size() != 0 && $urandom_range(0, 99) < 65) begin
                    r = stores[$urandom_range(0, stores.size() - 1)];
                    if ($urandom_range(0, 4) == 0) begin
                        case ($urandom_range(0, 3))
                            0: r = mk_ref(~r.fmt, r.size, r.rn, r.off);
                            1: r.size = r.size ^ 2'd1;
                            2: r.rn = r.rn ^ 5'd1;
                            default: r.off = r.off ^ 12'd1;
                        endcase
                    end
                end else begin
                    r = random_ref();
                end
                w = encode_ref(r, 2'($urandom_range(OPC_LOAD_U, OPC_LOAD_S32)));
            end
            add_word(w, n == len - 1);
        end
    endtask

    task automatic build_directed();
        t_mem_ref r;
        quiet_gaps = 1'b0;
        // unrecognized words, all zeros and all ones
        add_word(32'h0000_0000, 1'b1);
        add_word(32'hFFFF_FFFF, 1'b1);
        // imm12 store then load at the field maxima; load is the last word
        r = mk_ref(1'b0, 2'd3, 5'd31, 12'hFFF);
        add_word(encode_ref(r, OPC_STORE), 1'b0);
        add_word(encode_ref(r, OPC_LOAD_U), 1'b1);
        // unscaled form, noise in between
        r = mk_ref(1'b1, 2'd0, 5'd0, 12'h1FF);
        add_word(encode_ref(r, OPC_STORE), 1'b0);
        add_word(32'hFFFF_FFFF, 1'b0);
        add_word(encode_ref(r, OPC_LOAD_S32), 1'b1);
        // near misses: other format, other size, other base
        r = mk_ref(1'b0, 2'd1, 5'd5, 12'd5);
        add_word(encode_ref(r, OPC_STORE), 1'b0);
        add_word(encode_ref(mk_ref(1'b1, 2'd1, 5'd5, 12'd5), OPC_LOAD_S64), 1'b0);
        add_word(encode_ref(mk_ref(1'b0, 2'd2, 5'd5, 12'd5), OPC_LOAD_U), 1'b0);
        add_word(encode_ref(mk_ref(1'b0, 2'd1, 5'd4, 12'd5), OPC_LOAD_U), 1'b0);
        add_word(32'h0000_0000, 1'b1);
        // load ahead of its store does not alias
        r = mk_ref(1'b0, 2'd0, 5'd7, 12'd16);
        add_word(encode_ref(r, OPC_LOAD_U), 1'b0);
        add_word(encode_ref(r, OPC_STORE), 1'b1);
        // table was cleared by the last word
        add_word(encode_ref(r, OPC_LOAD_S64), 1'b1);
        // sticky flag survives later stores
        r = mk_ref(1'b1, 2'd2, 5'd9, 12'd3);
        add_word(encode_ref(r, OPC_STORE), 1'b0);
        add_word(encode_ref(r, OPC_LOAD_U), 1'b0);
        add_word(encode_ref(mk_ref(1'b0, 2'd2, 5'd9, 12'd3), OPC_STORE), 1'b1);
        // table full: the 33rd store is dropped, so its load must not alias
        for (int i = 0; i <= STORE_SLOTS; i++) begin
            add_word(encode_ref(mk_ref(1'b0, 2'd0, 5'd0, 12'(i)), OPC_STORE), 1'b0);
        end
        add_word(encode_ref(mk_ref(1'b0, 2'd0, 5'd0, 12'(STORE_SLOTS)), OPC_LOAD_U), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // input driver; the model runs here so a drain hold sees it up to date
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_idle_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_alias_word(s_axis_tdata, s_axis_tlast);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_idle_left > 0) begin
                    send_idle_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() != 0 && pending_words[0].drain) begin
                    if (expected_hazards.size() == 0) void'(pending_words.pop_front());
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    next_word      = pending_words.pop_front();
                    s_axis_tdata  <= next_word.word;
                    s_axis_tlast  <= next_word.last;
                    s_axis_tvalid <= 1'b1;
                    send_idle_left = next_word.idle;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor and receiver stalls
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_hold_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_hazards.size() == 0) begin
                    report_mismatch($sformatf("unexpected hazard word 0x%02h", m_axis_tdata));
                end else begin
                    if (m_axis_tdata[0] !== expected_hazards[0]) begin
                        report_mismatch($sformatf("hazard %b, expected %b",
                                                  m_axis_tdata[0], expected_hazards[0]));
                    end
                    if (m_axis_tdata[7:1] !== 7'd0) begin
                        report_mismatch($sformatf("pad bits 0x%02h", m_axis_tdata[7:1]));
                    end
                    void'(expected_hazards.pop_front());
                end
                hazards_seen++;
                // long hold-offs back the block up while the sender keeps going
                if (hazards_seen == 20 || hazards_seen == 70) begin
                    recv_hold_left = LONG_HOLD;
                end else if ((hazards_seen / 16) % 3 == 1) begin
                    recv_hold_left = 0;
                end else begin
                    recv_hold_left = $urandom_range(0, 9);
                end
            end
            if (recv_hold_left > 0) begin
                recv_hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        build_directed();
        add_drain();
        while (scanned_items < RANDOM_ITEMS) begin
            quiet_gaps = ($urandom_range(0, 3) == 0);
            add_random_region();
            if (!mid_drained && scanned_items >= RANDOM_ITEMS / 2) begin
                add_drain();
                mid_drained = 1'b1;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_hazards.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS store_load_alias_detector_top");
        end else begin
            $display("FAIL store_load_alias_detector_top");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL store_load_alias_detector_top");
        $finish;
    end

endmodule
